// ===== sv/qat_pkg.sv =====
// Package for the quoted argument tokenizer.
// Holds the character codes, result kinds and the result record type.
// Depends on nothing.
`timescale 1ns / 1ps

package qat_pkg;

   localparam int LINE_LENGTH_DEFAULT = 64;

   localparam int CH_W    = 8;
   localparam int IDX_W   = 4;
   localparam int FPOS_W  = 6;
   localparam int KIND_W  = 2;
   localparam int TDATA_W = 24;

   localparam logic [FPOS_W-1:0] FPOS_MAX = 6'd63;
   localparam logic [IDX_W-1:0]  MAX_ARGS_RESET = 4'd8;

   localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
   localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CH_W-1:0] CH_DQ    = 8'h22;
   localparam logic [CH_W-1:0] CH_SQ    = 8'h27;

   localparam logic [KIND_W-1:0] KIND_ARG = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CUT = 2'd1;
   localparam logic [KIND_W-1:0] KIND_END = 2'd2;

   typedef struct packed {
      logic                has_arg;
      logic                has_end;
      logic [KIND_W-1:0]   kind;
      logic [IDX_W-1:0]    arg_index;
      logic [FPOS_W-1:0]   arg_start;
      logic [FPOS_W-1:0]   arg_length;
      logic [IDX_W-1:0]    arg_count;
      logic                overflow;
   } qat_rec_type;

endpackage

// ===== sv/qat_core.sv =====
// Line state of the tokenizer and the result record for each character.
// Depends on qat_pkg.
`timescale 1ns / 1ps

module qat_core #(
   parameter int LINE_LENGTH = qat_pkg::LINE_LENGTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wen,
   input  logic [qat_pkg::IDX_W-1:0]       csr_wdata,
   input  logic                            in_fire,
   input  logic [qat_pkg::CH_W-1:0]        ch,
   output logic                            push,
   output qat_pkg::qat_rec_type            rec
);
   import qat_pkg::*;

   localparam int POS_W = $clog2(LINE_LENGTH + 1);
   localparam int SP_W  = $clog2(LINE_LENGTH);
   localparam int EXT_W = SP_W + 7;
   localparam logic [POS_W-1:0] POS_FULL = POS_W'(LINE_LENGTH);
   localparam logic [SP_W-1:0]  POS_LAST = SP_W'(LINE_LENGTH - 1);

   typedef enum logic [1:0] {MODE_BETWEEN, MODE_BARE, MODE_DQ, MODE_SQ} mode_type;

   mode_type          mode_ff, mode_in;
   logic [POS_W-1:0]  position_ff, position_in;
   logic [IDX_W-1:0]  count_ff, count_in;
   logic [SP_W-1:0]   start_ff, start_in;
   logic              ovf_ff, ovf_in;
   logic [IDX_W-1:0]  max_args_ff;
   logic [SP_W-1:0]   p_now;
   logic [SP_W-1:0]   p_next;
   logic [SP_W-1:0]   len_raw;
   logic              close_arg;

   function automatic logic [SP_W-1:0] clip_pos(input logic [POS_W-1:0] x);
      return (x == POS_FULL) ? POS_LAST : SP_W'(x);
   endfunction

   function automatic logic [FPOS_W-1:0] sat_field(input logic [SP_W-1:0] x);
      logic [EXT_W-1:0] e;
      e = EXT_W'(x);
      return (e > EXT_W'(FPOS_MAX)) ? FPOS_MAX : e[FPOS_W-1:0];
   endfunction

   always_comb begin
      p_now       = clip_pos(position_ff);
      position_in = (position_ff == POS_FULL) ? position_ff : position_ff + POS_W'(1);
      p_next      = clip_pos(position_in);
      len_raw     = (p_now >= start_ff) ? p_now - start_ff : '0;
      mode_in     = mode_ff;
      count_in    = count_ff;
      start_in    = start_ff;
      ovf_in      = ovf_ff | (position_ff == POS_FULL);
      close_arg   = 1'b0;
      rec            = '0;
      rec.kind       = KIND_ARG;
      rec.arg_index  = count_ff - IDX_W'(1);
      rec.arg_start  = sat_field(start_ff);
      rec.arg_length = sat_field(len_raw);
      rec.arg_count  = count_ff;
      rec.overflow   = ovf_ff;
      if (ch == CH_NUL) begin
         rec.has_end = 1'b1;
         rec.has_arg = (mode_ff != MODE_BETWEEN);
         rec.kind    = (mode_ff == MODE_BARE) ? KIND_ARG : KIND_CUT;
         mode_in     = MODE_BETWEEN;
         position_in = '0;
         count_in    = '0;
         start_in    = '0;
         ovf_in      = 1'b0;
      end else begin
         rec.overflow = ovf_in;
         unique case (mode_ff)
            MODE_BETWEEN: begin
               if (!(count_ff >= max_args_ff || ch == CH_SPACE)) begin
                  if (ch == CH_DQ || ch == CH_SQ) begin
                     mode_in  = (ch == CH_DQ) ? MODE_DQ : MODE_SQ;
                     start_in = p_next;
                  end else begin
                     mode_in  = MODE_BARE;
                     start_in = p_now;
                  end
                  count_in = count_ff + IDX_W'(1);
               end
            end
            MODE_BARE: close_arg = (ch == CH_SPACE);
            MODE_DQ:   close_arg = (ch == CH_DQ);
            MODE_SQ:   close_arg = (ch == CH_SQ);
            default:   close_arg = 1'b0;
         endcase
         if (close_arg) begin
            rec.has_arg = 1'b1;
            mode_in     = MODE_BETWEEN;
         end
      end
      push = in_fire && (rec.has_arg || rec.has_end);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_BETWEEN;
         position_ff <= '0;
         count_ff    <= '0;
         start_ff    <= '0;
         ovf_ff      <= 1'b0;
         max_args_ff <= MAX_ARGS_RESET;
      end else begin
         if (in_fire) begin
            mode_ff     <= mode_in;
            position_ff <= position_in;
            count_ff    <= count_in;
            start_ff    <= start_in;
            ovf_ff      <= ovf_in;
         end
         if (csr_wen) begin
            max_args_ff <= csr_wdata;
         end
      end
   end

endmodule

// ===== sv/qat_outq.sv =====
// Two-record result queue that serializes each record into one or two
// result transfers. Depends on qat_pkg.
`timescale 1ns / 1ps

module qat_outq (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  qat_pkg::qat_rec_type          rec_in,
   output logic                          full,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [qat_pkg::TDATA_W-1:0]   rsp_tdata,
   output logic [qat_pkg::KIND_W-1:0]    rsp_tuser,
   output logic                          rsp_tlast
);
   import qat_pkg::*;

   qat_rec_type  slot_ff [2];
   logic [1:0]   cnt_ff, cnt_in;
   logic         wr_ptr_ff, rd_ptr_ff, phase_ff;
   qat_rec_type  head;
   logic         show_arg;
   logic         fire, pop;

   always_comb begin
      head       = slot_ff[rd_ptr_ff];
      show_arg   = head.has_arg && !phase_ff;
      rsp_tvalid = (cnt_ff != 2'd0);
      full       = (cnt_ff == 2'd2);
      rsp_tlast  = !show_arg || !head.has_end;
      fire       = rsp_tvalid && rsp_tready;
      pop        = fire && rsp_tlast;
      cnt_in     = cnt_ff + {1'b0, push} - {1'b0, pop};
      rsp_tdata  = '0;
      rsp_tdata[19:16] = head.arg_count;
      rsp_tdata[20]    = head.overflow;
      if (show_arg) begin
         rsp_tuser        = head.kind;
         rsp_tdata[3:0]   = head.arg_index;
         rsp_tdata[9:4]   = head.arg_start;
         rsp_tdata[15:10] = head.arg_length;
      end else begin
         rsp_tuser = KIND_END;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         phase_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
            phase_ff  <= 1'b0;
         end else if (fire) begin
            phase_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= rec_in;
      end
   end

endmodule

// ===== sv/quoted_argument_tokenizer_unit.sv =====
// Quoted argument tokenizer: splits a command line, one character per
// transfer, into arguments with index, start and length.
//
// Input channel req_*: one character per transfer in req_tdata; a zero byte
// ends the line. Result channel rsp_*: one result per transfer, rsp_tuser
// gives its kind (argument closed, argument cut inside quotes, line end) and
// rsp_tlast marks the last result caused by one character.
// Configuration: csr_wen writes csr_wdata into max_arguments; write it only
// while the block is idle.
// Throughput: one character per cycle while the result queue is not full. A
// character that closes an argument or ends the line places a record in a
// two-entry result queue; the record is registered before its result is
// shown. A line end with an open argument gives two results, so the result
// port sets the rate when such records follow one another.
// When the receiver stalls, the queue holds up to two records and req_tready
// falls while it is full.
// Reset clears the line state and the queue and sets max_arguments to 8.
`timescale 1ns / 1ps

module quoted_argument_tokenizer_unit #(
   parameter int LINE_LENGTH = qat_pkg::LINE_LENGTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wen,
   input  logic [qat_pkg::IDX_W-1:0]     csr_wdata,   // max_arguments
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [qat_pkg::CH_W-1:0]      req_tdata,   // ch
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // arg_index, arg_start, arg_length, arg_count, overflow, zero fill
   output logic [qat_pkg::TDATA_W-1:0]   rsp_tdata,
   output logic [qat_pkg::KIND_W-1:0]    rsp_tuser,   // kind
   output logic                          rsp_tlast    // last
);
   import qat_pkg::*;

   qat_rec_type rec;
   logic        push;
   logic        full;
   logic        in_fire;

   assign req_tready = !full;
   assign in_fire    = req_tvalid && req_tready;

   qat_core #(
      .LINE_LENGTH (LINE_LENGTH)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_wdata (csr_wdata),
      .in_fire   (in_fire),
      .ch        (req_tdata),
      .push      (push),
      .rec       (rec)
   );

   qat_outq u_outq (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .rec_in     (rec),
      .full       (full),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== sv/qat_checker.sv =====
// Port-level checks for the quoted argument tokenizer and their binding.
// Depends on qat_pkg and quoted_argument_tokenizer_unit.
`timescale 1ns / 1ps

module qat_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [qat_pkg::TDATA_W-1:0]   rsp_tdata,
   input logic [qat_pkg::KIND_W-1:0]    rsp_tuser,
   input logic                          rsp_tlast
);
   import qat_pkg::*;

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("Result queue not empty after reset.");

   a_end_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == KIND_END) |-> (rsp_tlast && rsp_tdata[15:0] == 16'd0))
      else $error("Line end result malformed.");

   a_cut_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == KIND_CUT) |-> !rsp_tlast)
      else $error("Cut argument not followed by a line end result.");

   a_cut_then_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tuser == KIND_CUT)
      |=> (rsp_tvalid && rsp_tuser == KIND_END))
      else $error("Line end result missing after a cut argument.");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("Stalled result changed.");

endmodule

bind quoted_argument_tokenizer_unit qat_checker u_qat_checker (.*);

// ===== tb/quoted_argument_tokenizer_unit_tb.sv =====
// Self-checking testbench for quoted_argument_tokenizer_unit.
// Drives command lines over the request stream and checks every response
// against its own model of the tokenizer or fixed expected results; depends on qat_pkg and the unit.
`timescale 1ns / 1ps

module quoted_argument_tokenizer_unit_tb;
   import qat_pkg::*;

   localparam int RANDOM_ITEMS   = 850;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PRESSURE_HOLD  = 80;
   localparam int SETTLE_CYCLES  = 4;
   localparam int DRAIN_CYCLES   = 10;
   localparam int LINE_LEN       = LINE_LENGTH_DEFAULT;

   typedef enum logic [1:0] {SCAN_BETWEEN, SCAN_BARE, SCAN_DQ, SCAN_SQ} scan_mode_type;
   typedef enum logic {ROW_CHAR, ROW_CFG} row_kind_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [IDX_W-1:0]  arg_index;
      logic [FPOS_W-1:0] arg_start;
      logic [FPOS_W-1:0] arg_length;
      logic [IDX_W-1:0]  arg_count;
      logic              overflow;
      logic              last;
   } token_result_type;

   typedef struct {
      row_kind_type     kind;
      logic [7:0]       value;
      bit               typed;
      token_result_type want;
   } stim_row_type;

   logic                clock;
   logic                reset;
   logic                csr_wen;
   logic [IDX_W-1:0]    csr_wdata;
   logic                req_tvalid;
   logic                req_tready;
   logic [CH_W-1:0]     req_tdata;
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [TDATA_W-1:0]  rsp_tdata;
   logic [KIND_W-1:0]   rsp_tuser;
   logic                rsp_tlast;

   token_result_type tokens_due[$];
   token_result_type step_results[$];
   logic [7:0]       line_chars[$];
   stim_row_type     dir_rows[$];

   scan_mode_type scan_mode;
   int            scan_pos;
   int            arg_total;
   int            arg_begin;
   bit            line_ovf;
   int            max_args;

   int mismatches;
   int chars_sent;
   int idle_cycles;
   bit no_idle;
   bit pressure;
   bit stall_request;

   quoted_argument_tokenizer_unit #(.LINE_LENGTH(LINE_LEN)) DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int clip_pos(input int x);
      return (x > LINE_LEN - 1) ? LINE_LEN - 1 : x;
   endfunction

   function automatic string fmt_result(input token_result_type r);
      return $sformatf("kind=%0d idx=%0d start=%0d len=%0d count=%0d ovf=%0d last=%0d",
                       r.kind, r.arg_index, r.arg_start, r.arg_length,
                       r.arg_count, r.overflow, r.last);
   endfunction

   function automatic void add_result(input logic [KIND_W-1:0] kind, input int idx,
                                      input int st, input int len);
      token_result_type r;
      r.kind       = kind;
      r.arg_index  = idx[IDX_W-1:0];
      r.arg_start  = (st > FPOS_MAX) ? FPOS_MAX : st[FPOS_W-1:0];
      r.arg_length = (len > FPOS_MAX) ? FPOS_MAX : len[FPOS_W-1:0];
      r.arg_count  = arg_total[IDX_W-1:0];
      r.overflow   = line_ovf;
      r.last       = 1'b0;
      step_results.push_back(r);
   endfunction

   function automatic void close_arg(input logic [KIND_W-1:0] kind, input int stop);
      add_result(kind, (arg_total - 1) & 15, arg_begin,
                 (stop >= arg_begin) ? stop - arg_begin : 0);
   endfunction

   function automatic void predict_tokens(input logic [7:0] c);
      int p;
      p = clip_pos(scan_pos);
      step_results.delete();
      if (c == CH_NUL) begin
         if (scan_mode == SCAN_BARE) close_arg(KIND_ARG, p);
         else if (scan_mode != SCAN_BETWEEN) close_arg(KIND_CUT, p);
         add_result(KIND_END, 0, 0, 0);
         scan_mode = SCAN_BETWEEN;
         scan_pos  = 0;
         arg_total = 0;
         arg_begin = 0;
         line_ovf  = 1'b0;
      end else begin
         if (scan_pos >= LINE_LEN) line_ovf = 1'b1;
         else scan_pos++;
         case (scan_mode)
            SCAN_BETWEEN: begin
               if (arg_total < max_args && c != CH_SPACE) begin
                  if (c == CH_DQ || c == CH_SQ) begin
                     scan_mode = (c == CH_DQ) ? SCAN_DQ : SCAN_SQ;
                     arg_begin = clip_pos(scan_pos);
                  end else begin
                     scan_mode = SCAN_BARE;
                     arg_begin = p;
                  end
                  arg_total = (arg_total + 1) & 15;
               end
            end
            SCAN_BARE: begin
               if (c == CH_SPACE) begin
                  close_arg(KIND_ARG, p);
                  scan_mode = SCAN_BETWEEN;
               end
            end
            SCAN_DQ: begin
               if (c == CH_DQ) begin
                  close_arg(KIND_ARG, p);
                  scan_mode = SCAN_BETWEEN;
               end
            end
            default: begin
               if (c == CH_SQ) begin
                  close_arg(KIND_ARG, p);
                  scan_mode = SCAN_BETWEEN;
               end
            end
         endcase
      end
      if (step_results.size() > 0) step_results[step_results.size()-1].last = 1'b1;
   endfunction

   function automatic int pick_gap();
      int r;
      if (no_idle || pressure) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(5, 20);
   endfunction

   function automatic logic [7:0] rand_char(input bit no_space, input bit no_dq,
                                            input bit no_sq);
      logic [7:0] c;
      do begin
         if ($urandom_range(0, 1)) c = 8'(8'h61 + $urandom_range(0, 25));
         else c = 8'($urandom_range(1, 255));
      end while ((no_space && c == CH_SPACE) || (no_dq && c == CH_DQ) ||
                 (no_sq && c == CH_SQ));
      return c;
   endfunction

   // Builds one command line, terminator included, into line_chars.
   function automatic void build_line();
      int         r;
      int         n;
      int         len;
      int         forced;
      int         kind;
      bit         broken;
      logic [7:0] q;
      line_chars.delete();
      r = $urandom_range(0, 99);
      if (r < 8) begin
         len    = $urandom_range(60, 72);
         forced = $urandom_range(60, 66);
         for (int i = 0; i < len; i++) begin
            if (i == forced) line_chars.push_back($urandom_range(0, 1) ? CH_DQ : CH_SQ);
            else begin
               case ($urandom_range(0, 5))
                  0: line_chars.push_back(CH_SPACE);
                  1: line_chars.push_back(CH_DQ);
                  2: line_chars.push_back(CH_SQ);
                  default: line_chars.push_back(rand_char(1, 1, 1));
               endcase
            end
         end
      end else if (r < 22) begin
         len = $urandom_range(0, 20);
         repeat (len) line_chars.push_back(8'($urandom_range(1, 255)));
      end else begin
         n      = ($urandom_range(0, 99) < 15) ? $urandom_range(8, 17) : $urandom_range(0, 5);
         broken = ($urandom_range(0, 9) == 0);
         repeat ($urandom_range(0, 2)) line_chars.push_back(CH_SPACE);
         for (int a = 0; a < n; a++) begin
            kind = $urandom_range(0, 2);
            len  = $urandom_range(0, 6);
            if (kind == 0) begin
               line_chars.push_back(rand_char(1, 1, 1));
               repeat (len) line_chars.push_back(rand_char(1, 0, 0));
               repeat ($urandom_range(1, 2)) line_chars.push_back(CH_SPACE);
            end else begin
               q = (kind == 1) ? CH_DQ : CH_SQ;
               line_chars.push_back(q);
               repeat (len) begin
                  if ($urandom_range(0, 4) == 0) line_chars.push_back(CH_SPACE);
                  else line_chars.push_back(rand_char(0, q == CH_DQ, q == CH_SQ));
               end
               if (!(broken && a == n - 1)) begin
                  line_chars.push_back(q);
                  if ($urandom_range(0, 2) != 0)
                     repeat ($urandom_range(1, 2)) line_chars.push_back(CH_SPACE);
               end
            end
         end
      end
      line_chars.push_back(CH_NUL);
   endfunction

   // Called and returning at a falling edge; req_tvalid stays high on return.
   task automatic send_char(input logic [7:0] c, input bit typed,
                            input token_result_type want);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 8'($urandom_range(0, 255));
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      do @(posedge clock); while (!req_tready);
      predict_tokens(c);
      if (typed) tokens_due.push_back(want);
      else foreach (step_results[i]) tokens_due.push_back(step_results[i]);
      chars_sent++;
      @(negedge clock);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (tokens_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_max_args(input logic [IDX_W-1:0] v);
      csr_wen   <= 1'b1;
      csr_wdata <= v;
      max_args   = v;
      @(negedge clock);
      csr_wen   <= 1'b0;
   endtask

   initial begin : rsp_side
      int stall_left;
      int r;
      stall_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_request) begin
            stall_left    = PRESSURE_HOLD;
            stall_request = 1'b0;
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else if (no_idle) begin
            rsp_tready <= 1'b1;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
               rsp_tready <= 1'b1;
            end else if (r < 95) begin
               rsp_tready <= 1'b0;
               stall_left  = $urandom_range(0, 3);
            end else begin
               rsp_tready <= 1'b0;
               stall_left  = $urandom_range(5, 25);
            end
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      token_result_type got;
      token_result_type want;
      got.kind       = rsp_tuser;
      got.arg_index  = rsp_tdata[3:0];
      got.arg_start  = rsp_tdata[9:4];
      got.arg_length = rsp_tdata[15:10];
      got.arg_count  = rsp_tdata[19:16];
      got.overflow   = rsp_tdata[20];
      got.last       = rsp_tlast;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (tokens_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: %s", fmt_result(got));
         end else begin
            want = tokens_due.pop_front();
            if (got.kind != want.kind || got.arg_index != want.arg_index ||
                got.arg_start != want.arg_start || got.arg_length != want.arg_length ||
                got.arg_count != want.arg_count || got.overflow != want.overflow ||
                got.last != want.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result mismatch: expected %s, got %s",
                           fmt_result(want), fmt_result(got));
            end
         end
      end
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin : req_side
      int              phase_no;
      int              cut;
      logic [IDX_W-1:0] setting;
      reset         = 1'b1;
      csr_wen       = 1'b0;
      csr_wdata     = '0;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      mismatches    = 0;
      chars_sent    = 0;
      idle_cycles   = 0;
      no_idle       = 1'b0;
      pressure      = 1'b0;
      stall_request = 1'b0;
      scan_mode     = SCAN_BETWEEN;
      scan_pos      = 0;
      arg_total     = 0;
      arg_begin     = 0;
      line_ovf      = 1'b0;
      max_args      = MAX_ARGS_RESET;

      dir_rows.push_back('{ROW_CHAR, CH_NUL, 1, '{KIND_END, 4'd0, 6'd0, 6'd0, 4'd0, 1'b0, 1'b1}});
      dir_rows.push_back('{ROW_CHAR, 8'h61, 0, '0});
      dir_rows.push_back('{ROW_CHAR, 8'hFF, 0, '0});
      dir_rows.push_back('{ROW_CHAR, CH_SPACE, 0, '0});
      dir_rows.push_back('{ROW_CHAR, CH_DQ, 0, '0});
      dir_rows.push_back('{ROW_CHAR, CH_SPACE, 0, '0});
      dir_rows.push_back('{ROW_CHAR, CH_DQ, 1, '{KIND_ARG, 4'd1, 6'd4, 6'd1, 4'd2, 1'b0, 1'b1}});
      dir_rows.push_back('{ROW_CHAR, CH_SQ, 0, '0});
      dir_rows.push_back('{ROW_CHAR, 8'h62, 0, '0});
      dir_rows.push_back('{ROW_CHAR, CH_SQ, 0, '0});
      dir_rows.push_back('{ROW_CHAR, 8'h01, 0, '0});
      dir_rows.push_back('{ROW_CHAR, CH_DQ, 0, '0});
      dir_rows.push_back('{ROW_CHAR, CH_SQ, 0, '0});
      dir_rows.push_back('{ROW_CHAR, CH_NUL, 0, '0});
      dir_rows.push_back('{ROW_CHAR, CH_SQ, 0, '0});
      dir_rows.push_back('{ROW_CHAR, 8'h63, 0, '0});
      dir_rows.push_back('{ROW_CHAR, CH_NUL, 0, '0});
      dir_rows.push_back('{ROW_CHAR, CH_DQ, 0, '0});
      dir_rows.push_back('{ROW_CHAR, CH_NUL, 0, '0});
      dir_rows.push_back('{ROW_CFG, 8'd1, 0, '0});
      dir_rows.push_back('{ROW_CHAR, 8'h78, 0, '0});
      dir_rows.push_back('{ROW_CHAR, CH_SPACE, 1, '{KIND_ARG, 4'd0, 6'd0, 6'd1, 4'd1, 1'b0, 1'b1}});
      dir_rows.push_back('{ROW_CHAR, 8'h79, 0, '0});
      dir_rows.push_back('{ROW_CHAR, CH_DQ, 0, '0});
      dir_rows.push_back('{ROW_CHAR, CH_NUL, 1, '{KIND_END, 4'd0, 6'd0, 6'd0, 4'd1, 1'b0, 1'b1}});
      dir_rows.push_back('{ROW_CFG, 8'd0, 0, '0});
      dir_rows.push_back('{ROW_CHAR, 8'h7A, 0, '0});
      dir_rows.push_back('{ROW_CHAR, CH_NUL, 1, '{KIND_END, 4'd0, 6'd0, 6'd0, 4'd0, 1'b0, 1'b1}});

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_CFG) begin
            settle();
            write_max_args(dir_rows[i].value[IDX_W-1:0]);
         end else begin
            send_char(dir_rows[i].value, dir_rows[i].typed, dir_rows[i].want);
         end
      end

      chars_sent = 0;
      phase_no   = 0;
      while (chars_sent < RANDOM_ITEMS) begin
         case (phase_no)
            0:       setting = 4'd15;
            1:       setting = 4'd1;
            2:       setting = 4'd0;
            default: setting = 4'($urandom_range(0, 15));
         endcase
         settle();
         write_max_args(setting);
         no_idle  = (phase_no % 4 == 1);
         pressure = (phase_no == 3);
         if (pressure) stall_request = 1'b1;
         repeat ($urandom_range(3, 8)) begin
            build_line();
            foreach (line_chars[i]) send_char(line_chars[i], 0, '0);
         end
         if ($urandom_range(0, 3) == 0) begin
            build_line();
            cut = line_chars.size() / 2;
            for (int i = 0; i < cut; i++) send_char(line_chars[i], 0, '0);
         end
         pressure = 1'b0;
         phase_no++;
      end

      req_tvalid <= 1'b0;
      while (tokens_due.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatches == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

endmodule

// ===== quoted_argument_tokenizer_unit.f =====
sv/qat_pkg.sv
sv/qat_core.sv
sv/qat_outq.sv
sv/quoted_argument_tokenizer_unit.sv
sv/qat_checker.sv
tb/quoted_argument_tokenizer_unit_tb.sv
